// ===== hdl/swt_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// swt_pkg
// Shared types, codes and character constants of the shell word tokenizer.
// ============================================================================
package swt_pkg;

    // default limits
    localparam int MAX_TOKENS_DEF     = 96;
    localparam int OPERATOR_SLOTS_DEF = 32;

    // result kinds
    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_WEND  = 2'd1;
    localparam logic [1:0] KIND_OPER  = 2'd2;
    localparam logic [1:0] KIND_LEND  = 2'd3;

    // operator codes
    localparam logic [2:0] OP_LT    = 3'd0;
    localparam logic [2:0] OP_GT    = 3'd1;
    localparam logic [2:0] OP_GTGT  = 3'd2;
    localparam logic [2:0] OP_PIPE  = 3'd3;
    localparam logic [2:0] OP_SEMI  = 3'd4;
    localparam logic [2:0] OP_AMP   = 3'd5;
    localparam logic [2:0] OP_NONE  = 3'd0;

    // quote modes
    localparam logic [1:0] QM_NONE   = 2'd0;
    localparam logic [1:0] QM_SINGLE = 2'd1;
    localparam logic [1:0] QM_DOUBLE = 2'd2;

    // characters
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;

    localparam int RES_SLOTS = 3;

    // one result word without the per-step flags
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [2:0] operator_code;
        logic [6:0] token_index;
    } result_t;

    // all results of one input word
    typedef struct packed {
        logic [1:0]                count;
        logic                      limit_hit;
        result_t [RES_SLOTS-1:0]   res;
    } batch_t;

    // operator lookup: valid flag and code
    typedef struct packed {
        logic       valid;
        logic [2:0] code;
    } op_lookup_t;

    function automatic op_lookup_t op_of(logic [7:0] c);
        op_lookup_t r;
        r.valid = 1'b1;
        case (c)
            CH_LT:   r.code = OP_LT;
            CH_GT:   r.code = OP_GT;
            CH_PIPE: r.code = OP_PIPE;
            CH_SEMI: r.code = OP_SEMI;
            CH_AMP:  r.code = OP_AMP;
            default:
            begin
                r.valid = 1'b0;
                r.code  = OP_NONE;
            end
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/swt_if.sv =====
`timescale 1ns / 1ps
// ============================================================================
// swt_if
// Valid/ready channels: command byte input and token result output.
// ============================================================================
interface swt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       line_end;

    modport source (output valid, ch, line_end, input ready);
    modport sink   (input valid, ch, line_end, output ready);
endinterface

interface swt_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] data;
    logic [2:0] operator_code;
    logic [6:0] token_index;
    logic       limit_hit;
    logic       last;

    modport source (output valid, kind, data, operator_code, token_index, limit_hit, last,
                    input ready);
    modport sink   (input valid, kind, data, operator_code, token_index, limit_hit, last,
                    output ready);
endinterface

// ===== hdl/swt_core.sv =====
`timescale 1ns / 1ps
// ============================================================================
// swt_core
// Tokenizer state registers and the single-pass step logic that turns one
// byte into up to three results.
// ============================================================================
module swt_core #(
    parameter int MAX_TOKENS     = swt_pkg::MAX_TOKENS_DEF,
    parameter int OPERATOR_SLOTS = swt_pkg::OPERATOR_SLOTS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic [7:0]      ch,
    input  logic            line_end,
    output swt_pkg::batch_t batch
);
    import swt_pkg::*;

    localparam logic [6:0] MAX_TOK = 7'(MAX_TOKENS);
    localparam logic [6:0] OP_SLOT = 7'(OPERATOR_SLOTS);

    logic [1:0] qm_reg,  qm_next;
    logic       esc_reg, esc_next;
    logic       gp_reg,  gp_next;
    logic       iw_reg,  iw_next;
    logic [6:0] tc_reg,  tc_next;
    logic       hlt_reg, hlt_next;

    // append one result when a slot is left
    function automatic batch_t push(batch_t b, logic [1:0] kind, logic [7:0] data,
                                    logic [2:0] op, logic [6:0] idx);
        batch_t r;
        r = b;
        if (r.count != 2'd3)
        begin
            r.res[r.count].kind          = kind;
            r.res[r.count].data          = data;
            r.res[r.count].operator_code = op;
            r.res[r.count].token_index   = idx;
            r.count                      = r.count + 2'd1;
        end
        return r;
    endfunction

    // step logic
    always_comb
    begin
        batch_t     b;
        logic [1:0] qm;
        logic       esc;
        logic       gp;
        logic       iw;
        logic [6:0] tc;
        logic       hlt;
        logic       take;
        op_lookup_t opl;

        b    = '0;
        qm   = qm_reg;
        esc  = esc_reg;
        gp   = gp_reg;
        iw   = iw_reg;
        tc   = tc_reg;
        hlt  = hlt_reg;
        take = 1'b0;
        opl  = op_of(ch);

        if (line_end)
        begin
            // flush pending state, then report the token count
            if (gp)
            begin
                gp = 1'b0;
                b  = push(b, KIND_OPER, 8'd0, OP_GT, tc);
                tc = tc + 7'd1;
            end
            if (iw && esc)
            begin
                esc = 1'b0;
                b   = push(b, KIND_BYTE, CH_BSLASH, OP_NONE, tc);
            end
            if (iw)
            begin
                b  = push(b, KIND_WEND, 8'd0, OP_NONE, tc);
                tc = tc + 7'd1;
            end
            b = push(b, KIND_LEND, 8'd0, OP_NONE, tc);
            b.limit_hit = hlt;
            qm  = QM_NONE;
            esc = 1'b0;
            gp  = 1'b0;
            iw  = 1'b0;
            tc  = 7'd0;
            hlt = 1'b0;
        end
        else
        begin
            if (!hlt)
            begin
                // one byte of lookahead after a greater-than
                if (gp)
                begin
                    gp = 1'b0;
                    if (ch == CH_GT)
                    begin
                        b  = push(b, KIND_OPER, 8'd0, OP_GTGT, tc);
                        tc = tc + 7'd1;
                    end
                    else
                    begin
                        b    = push(b, KIND_OPER, 8'd0, OP_GT, tc);
                        tc   = tc + 7'd1;
                        take = 1'b1;
                    end
                end
                else
                begin
                    take = 1'b1;
                end

                if (take)
                begin
                    if (iw && esc)
                    begin
                        esc = 1'b0;
                        b   = push(b, KIND_BYTE, ch, OP_NONE, tc);
                    end
                    else if (iw && qm == QM_SINGLE)
                    begin
                        if (ch == CH_SQUOTE)
                            qm = QM_NONE;
                        else
                            b = push(b, KIND_BYTE, ch, OP_NONE, tc);
                    end
                    else if (iw && qm == QM_DOUBLE)
                    begin
                        if (ch == CH_DQUOTE)
                            qm = QM_NONE;
                        else if (ch == CH_BSLASH)
                            esc = 1'b1;
                        else
                            b = push(b, KIND_BYTE, ch, OP_NONE, tc);
                    end
                    else if (ch == CH_SPACE || ch == CH_TAB)
                    begin
                        if (iw)
                        begin
                            b   = push(b, KIND_WEND, 8'd0, OP_NONE, tc);
                            tc  = tc + 7'd1;
                            iw  = 1'b0;
                            qm  = QM_NONE;
                            esc = 1'b0;
                        end
                    end
                    else if (opl.valid)
                    begin
                        // an operator ends the current word and starts a token
                        if (iw)
                        begin
                            b   = push(b, KIND_WEND, 8'd0, OP_NONE, tc);
                            tc  = tc + 7'd1;
                            iw  = 1'b0;
                            qm  = QM_NONE;
                            esc = 1'b0;
                        end
                        if (tc >= MAX_TOK || tc >= OP_SLOT)
                            hlt = 1'b1;
                        else if (ch == CH_GT)
                            gp = 1'b1;
                        else
                        begin
                            b  = push(b, KIND_OPER, 8'd0, opl.code, tc);
                            tc = tc + 7'd1;
                        end
                    end
                    else if (!iw && tc >= MAX_TOK)
                    begin
                        hlt = 1'b1;
                    end
                    else
                    begin
                        if (!iw)
                        begin
                            iw = 1'b1;
                            qm = QM_NONE;
                        end
                        if (ch == CH_SQUOTE)
                            qm = QM_SINGLE;
                        else if (ch == CH_DQUOTE)
                            qm = QM_DOUBLE;
                        else if (ch == CH_BSLASH)
                            esc = 1'b1;
                        else
                            b = push(b, KIND_BYTE, ch, OP_NONE, tc);
                    end
                end
            end
            b.limit_hit = hlt;
        end

        batch    = b;
        qm_next  = qm;
        esc_next = esc;
        gp_next  = gp;
        iw_next  = iw;
        tc_next  = tc;
        hlt_next = hlt;
    end

    // state registers, updated on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qm_reg  <= QM_NONE;
            esc_reg <= 1'b0;
            gp_reg  <= 1'b0;
            iw_reg  <= 1'b0;
            tc_reg  <= 7'd0;
            hlt_reg <= 1'b0;
        end
        else if (accept)
        begin
            qm_reg  <= qm_next;
            esc_reg <= esc_next;
            gp_reg  <= gp_next;
            iw_reg  <= iw_next;
            tc_reg  <= tc_next;
            hlt_reg <= hlt_next;
        end
    end

endmodule

// ===== hdl/swt_outq.sv =====
`timescale 1ns / 1ps
// ============================================================================
// swt_outq
// Result register for one step; hands results out one per cycle on tok.ready.
// ============================================================================
module swt_outq (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  swt_pkg::batch_t  batch,
    output logic             free,
    swt_out_if.source        tok
);
    import swt_pkg::*;

    logic                    busy_reg,  busy_next;
    logic [1:0]              cnt_reg,   cnt_next;
    logic [1:0]              pos_reg,   pos_next;
    logic                    limit_reg, limit_next;
    result_t [RES_SLOTS-1:0] res_reg;
    logic                    cur_last;
    result_t                 cur;

    assign cur_last = (pos_reg == cnt_reg - 2'd1);
    assign free     = !busy_reg || (tok.ready && cur_last);
    assign cur      = res_reg[pos_reg];

    // drive the output word
    assign tok.valid         = busy_reg;
    assign tok.kind          = cur.kind;
    assign tok.data          = cur.data;
    assign tok.operator_code = cur.operator_code;
    assign tok.token_index   = cur.token_index;
    assign tok.limit_hit     = limit_reg;
    assign tok.last          = cur_last;

    // next control state
    always_comb
    begin
        busy_next  = busy_reg;
        cnt_next   = cnt_reg;
        pos_next   = pos_reg;
        limit_next = limit_reg;
        if (load)
        begin
            busy_next  = (batch.count != 2'd0);
            cnt_next   = batch.count;
            pos_next   = 2'd0;
            limit_next = batch.limit_hit;
        end
        else if (busy_reg && tok.ready)
        begin
            if (cur_last)
                busy_next = 1'b0;
            else
                pos_next = pos_reg + 2'd1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            cnt_reg   <= 2'd0;
            pos_reg   <= 2'd0;
            limit_reg <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            cnt_reg   <= cnt_next;
            pos_reg   <= pos_next;
            limit_reg <= limit_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= batch.res;
    end

endmodule

// ===== hdl/shell_word_tokenizer_top.sv =====
`timescale 1ns / 1ps
// Results of a byte are registered and appear in the cycle after it is accepted.
// Throughput: one byte per cycle while each byte yields at most one result
//   and tok is ready; else the input waits until the last result is taken.
// Zero-result bytes pass at one per cycle whenever the result register is free.
// Reset: rst_n clears quote, lookahead, word and count state and empties output.
// ============================================================================
// shell_word_tokenizer_top
// Streaming shell command-line tokenizer: words, quotes, escapes, operators.
// ============================================================================
module shell_word_tokenizer_top #(
    parameter int MAX_TOKENS     = swt_pkg::MAX_TOKENS_DEF,
    parameter int OPERATOR_SLOTS = swt_pkg::OPERATOR_SLOTS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    swt_in_if.sink    cmd,
    swt_out_if.source tok
);
    import swt_pkg::*;

    logic   free;
    logic   accept;
    batch_t batch;

    // input handshake
    assign cmd.ready = free;
    assign accept    = cmd.valid && free;

    // step logic and state
    swt_core #(
        .MAX_TOKENS     (MAX_TOKENS),
        .OPERATOR_SLOTS (OPERATOR_SLOTS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .ch       (cmd.ch),
        .line_end (cmd.line_end),
        .batch    (batch)
    );

    // result register and output sequencing
    swt_outq u_outq (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (accept),
        .batch (batch),
        .free  (free),
        .tok   (tok)
    );

endmodule

// ===== tb/tb_shell_word_tokenizer_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_shell_word_tokenizer_top
// Self-checking bench for the shell word tokenizer. A directed script walks
// words, quotes, escapes, operators and line ends. Random command lines then
// follow, with floods that run into the token limit and the operator slots.
// Typed script rows give the expected word; a behavioral tokenizer predicts
// the rest. Each word is compared field by field. Both channels idle at random.
// ============================================================================
module tb_shell_word_tokenizer_top;
    import swt_pkg::*;

    localparam int TOK_LIMIT       = MAX_TOKENS_DEF;
    localparam int OP_LIMIT        = OPERATOR_SLOTS_DEF;
    localparam int LINE_BYTES      = 460;
    localparam int WATCHDOG_CYCLES = 1000;
    localparam int TAIL_CYCLES     = 8;

    // one expected token word with its flags
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [2:0] op;
        logic [6:0] idx;
        logic       lim;
        logic       last;
    } token_t;

    // one row of the directed script
    typedef struct {
        logic [7:0] ch;
        logic       le;
        bit         typed;
        token_t     res;
    } row_t;

    logic clk;
    logic rst_n;

    swt_in_if  cmd_if ();
    swt_out_if tok_if ();

    shell_word_tokenizer_top #(
        .MAX_TOKENS     (TOK_LIMIT),
        .OPERATOR_SLOTS (OP_LIMIT)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .tok   (tok_if)
    );

    // tokenizer state of the predictor
    logic [1:0] quote_st;
    logic       esc_pend;
    logic       gt_pend;
    logic       in_word;
    logic [6:0] tok_cnt;
    logic       halted;

    // token words of the current byte
    token_t step_buf [RES_SLOTS];
    int     step_n;

    token_t pending_tokens [$];
    row_t   script [$];
    logic [7:0] oper_chars [5] = '{CH_LT, CH_GT, CH_PIPE, CH_SEMI, CH_AMP};

    int mismatches = 0;
    int fed_bytes  = 0;
    int idle_cycles;
    bit calm = 1'b0;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // idle cycles before a word, none during a calm stretch
    function automatic int draw_wait();
        return calm ? 0 : $urandom_range(0, 3);
    endfunction

    function automatic int oper_code(logic [7:0] c);
        case (c)
            CH_LT:   return OP_LT;
            CH_GT:   return OP_GT;
            CH_PIPE: return OP_PIPE;
            CH_SEMI: return OP_SEMI;
            CH_AMP:  return OP_AMP;
            default: return -1;
        endcase
    endfunction

    // byte mix leaning on the characters that steer the state machine
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 15))
            0, 1, 2, 3, 4, 5: return 8'(8'h61 + $urandom_range(0, 25));
            6:                return CH_SPACE;
            7:                return CH_TAB;
            8:                return CH_SQUOTE;
            9:                return CH_DQUOTE;
            10:               return CH_BSLASH;
            11:               return CH_GT;
            12:               return oper_chars[$urandom_range(0, 4)];
            default:          return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic row_t plain(logic [7:0] c, logic le);
        row_t r;
        r.ch    = c;
        r.le    = le;
        r.typed = 1'b0;
        r.res   = '0;
        return r;
    endfunction

    function automatic row_t typed(logic [7:0] c, logic le, logic [1:0] kind,
                                   logic [7:0] data, logic [2:0] op, logic [6:0] idx);
        row_t r;
        r.ch       = c;
        r.le       = le;
        r.typed    = 1'b1;
        r.res.kind = kind;
        r.res.data = data;
        r.res.op   = op;
        r.res.idx  = idx;
        r.res.lim  = 1'b0;
        r.res.last = 1'b1;
        return r;
    endfunction

    task automatic clear_state();
        quote_st = QM_NONE;
        esc_pend = 1'b0;
        gt_pend  = 1'b0;
        in_word  = 1'b0;
        tok_cnt  = '0;
        halted   = 1'b0;
    endtask

    // result slots beyond the third are dropped
    task automatic add_result(logic [1:0] kind, logic [7:0] data, logic [2:0] op);
        if (step_n < RES_SLOTS)
        begin
            step_buf[step_n].kind = kind;
            step_buf[step_n].data = data;
            step_buf[step_n].op   = op;
            step_buf[step_n].idx  = tok_cnt;
            step_buf[step_n].lim  = 1'b0;
            step_buf[step_n].last = 1'b0;
            step_n++;
        end
    endtask

    task automatic put_oper(logic [2:0] op);
        add_result(KIND_OPER, 8'h00, op);
        tok_cnt = tok_cnt + 7'd1;
    endtask

    task automatic close_word();
        add_result(KIND_WEND, 8'h00, OP_NONE);
        tok_cnt  = tok_cnt + 7'd1;
        in_word  = 1'b0;
        quote_st = QM_NONE;
        esc_pend = 1'b0;
    endtask

    // one byte once any pending '>' is resolved
    task automatic take_char(logic [7:0] c);
        if (in_word && esc_pend)
        begin
            esc_pend = 1'b0;
            add_result(KIND_BYTE, c, OP_NONE);
        end
        else if (in_word && quote_st == QM_SINGLE)
        begin
            if (c == CH_SQUOTE)
                quote_st = QM_NONE;
            else
                add_result(KIND_BYTE, c, OP_NONE);
        end
        else if (in_word && quote_st == QM_DOUBLE)
        begin
            if (c == CH_DQUOTE)
                quote_st = QM_NONE;
            else if (c == CH_BSLASH)
                esc_pend = 1'b1;
            else
                add_result(KIND_BYTE, c, OP_NONE);
        end
        else if (c == CH_SPACE || c == CH_TAB)
        begin
            if (in_word)
                close_word();
        end
        else if (oper_code(c) >= 0)
        begin
            // the word ends, then the operator takes a slot if one is free
            if (in_word)
                close_word();
            if (tok_cnt >= TOK_LIMIT || tok_cnt >= OP_LIMIT)
                halted = 1'b1;
            else if (c == CH_GT)
                gt_pend = 1'b1;
            else
                put_oper(3'(oper_code(c)));
        end
        else if (!in_word && tok_cnt >= TOK_LIMIT)
        begin
            halted = 1'b1;
        end
        else
        begin
            if (!in_word)
            begin
                in_word  = 1'b1;
                quote_st = QM_NONE;
            end
            if (c == CH_SQUOTE)
                quote_st = QM_SINGLE;
            else if (c == CH_DQUOTE)
                quote_st = QM_DOUBLE;
            else if (c == CH_BSLASH)
                esc_pend = 1'b1;
            else
                add_result(KIND_BYTE, c, OP_NONE);
        end
    endtask

    // predict the token words of one accepted input word
    task automatic tokenize(logic [7:0] c, logic le);
        logic lim_flag;
        step_n = 0;
        if (le)
        begin
            // flush lookahead and trailing backslash, close the word
            if (gt_pend)
            begin
                gt_pend = 1'b0;
                put_oper(OP_GT);
            end
            if (in_word && esc_pend)
            begin
                esc_pend = 1'b0;
                add_result(KIND_BYTE, CH_BSLASH, OP_NONE);
            end
            if (in_word)
                close_word();
            add_result(KIND_LEND, 8'h00, OP_NONE);
            lim_flag = halted;
            clear_state();
        end
        else
        begin
            if (!halted)
            begin
                if (gt_pend)
                begin
                    gt_pend = 1'b0;
                    if (c == CH_GT)
                        put_oper(OP_GTGT);
                    else
                    begin
                        put_oper(OP_GT);
                        take_char(c);
                    end
                end
                else
                    take_char(c);
            end
            lim_flag = halted;
        end
        for (int k = 0; k < step_n; k++)
        begin
            step_buf[k].lim  = lim_flag;
            step_buf[k].last = (k == step_n - 1);
        end
    endtask

    // drive one command word and queue what it should produce
    task automatic send_byte(logic [7:0] c, logic le, bit is_typed, token_t want);
        int gap;
        if ($urandom_range(0, 63) == 0)
            calm = ~calm;
        gap = draw_wait();
        if (gap > 0)
        begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_if.valid    <= 1'b1;
        cmd_if.ch       <= c;
        cmd_if.line_end <= le;
        do
            @(posedge clk);
        while (cmd_if.ready !== 1'b1);
        fed_bytes++;
        tokenize(c, le);
        if (is_typed)
            pending_tokens.push_back(want);
        else
            for (int k = 0; k < step_n; k++)
                pending_tokens.push_back(step_buf[k]);
    endtask

    // stimulus
    initial
    begin
        int len;
        int line_no;
        cmd_if.valid    = 1'b0;
        cmd_if.ch       = 8'h00;
        cmd_if.line_end = 1'b0;
        rst_n           = 1'b0;
        clear_state();

        // directed script
        script.push_back(typed(8'h61, 1'b0, KIND_BYTE, 8'h61, OP_NONE, 7'd0));
        script.push_back(typed(8'h00, 1'b0, KIND_BYTE, 8'h00, OP_NONE, 7'd0));
        script.push_back(typed(8'hFF, 1'b0, KIND_BYTE, 8'hFF, OP_NONE, 7'd0));
        script.push_back(typed(CH_SPACE, 1'b0, KIND_WEND, 8'h00, OP_NONE, 7'd0));
        // empty single-quoted word
        script.push_back(plain(CH_SQUOTE, 1'b0));
        script.push_back(plain(CH_SQUOTE, 1'b0));
        script.push_back(typed(CH_TAB, 1'b0, KIND_WEND, 8'h00, OP_NONE, 7'd1));
        // escaped quote inside double quotes
        script.push_back(plain(CH_DQUOTE, 1'b0));
        script.push_back(plain(CH_BSLASH, 1'b0));
        script.push_back(plain(CH_DQUOTE, 1'b0));
        script.push_back(plain(CH_DQUOTE, 1'b0));
        // operator right after a word, then >> and > followed by |
        script.push_back(typed(CH_GT, 1'b0, KIND_WEND, 8'h00, OP_NONE, 7'd2));
        script.push_back(typed(CH_GT, 1'b0, KIND_OPER, 8'h00, OP_GTGT, 7'd3));
        script.push_back(plain(CH_GT, 1'b0));
        script.push_back(plain(CH_PIPE, 1'b0));
        script.push_back(typed(CH_LT, 1'b0, KIND_OPER, 8'h00, OP_LT, 7'd6));
        script.push_back(typed(CH_SEMI, 1'b0, KIND_OPER, 8'h00, OP_SEMI, 7'd7));
        script.push_back(typed(CH_AMP, 1'b0, KIND_OPER, 8'h00, OP_AMP, 7'd8));
        // escaped space, then a backslash left pending at line end
        script.push_back(plain(CH_BSLASH, 1'b0));
        script.push_back(typed(CH_SPACE, 1'b0, KIND_BYTE, CH_SPACE, OP_NONE, 7'd9));
        script.push_back(plain(CH_BSLASH, 1'b0));
        script.push_back(plain(8'hA5, 1'b1));
        // double quote never closed
        script.push_back(plain(CH_DQUOTE, 1'b0));
        script.push_back(typed(8'h78, 1'b0, KIND_BYTE, 8'h78, OP_NONE, 7'd0));
        script.push_back(plain(8'h5A, 1'b1));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
            send_byte(script[i].ch, script[i].le, script[i].typed, script[i].res);

        // random command lines
        line_no = 0;
        while (fed_bytes < LINE_BYTES)
        begin
            line_no++;
            if (line_no % 9 == 3 && fed_bytes + 240 < LINE_BYTES)
            begin
                // enough short words to hit the token limit
                repeat (100)
                begin
                    send_byte(8'(8'h61 + $urandom_range(0, 25)), 1'b0, 1'b0, '0);
                    if ($urandom_range(0, 3) == 0)
                        send_byte(pick_byte(), 1'b0, 1'b0, '0);
                    send_byte(($urandom_range(0, 7) == 0) ? CH_TAB : CH_SPACE,
                              1'b0, 1'b0, '0);
                end
                repeat (4) send_byte(pick_byte(), 1'b0, 1'b0, '0);
            end
            else if (line_no % 9 == 6 && fed_bytes + 60 < LINE_BYTES)
            begin
                // operator run past the operator slots
                repeat (50)
                begin
                    if ($urandom_range(0, 7) == 0)
                        send_byte(8'(8'h61 + $urandom_range(0, 25)), 1'b0, 1'b0, '0);
                    send_byte(oper_chars[$urandom_range(0, 4)], 1'b0, 1'b0, '0);
                end
            end
            else
            begin
                len = $urandom_range(0, 24);
                repeat (len) send_byte(pick_byte(), 1'b0, 1'b0, '0);
            end
            send_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
        end
        cmd_if.valid <= 1'b0;

        // drain
        while (pending_tokens.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // token receiver with random stalls
    initial
    begin
        int stall;
        tok_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = draw_wait();
            if (stall > 0)
            begin
                tok_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            tok_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (tok_if.valid !== 1'b1);
        end
    end

    // unknown bits in the actual value count as a mismatch
    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // compare each accepted token word with the oldest expectation
    always @(posedge clk)
    begin : token_check
        token_t want;
        if (rst_n && tok_if.valid === 1'b1 && tok_if.ready === 1'b1)
        begin
            if (pending_tokens.size() == 0)
            begin
                $error("unexpected token word: kind %0d, data %0d, token_index %0d",
                       tok_if.kind, tok_if.data, tok_if.token_index);
                mismatches++;
            end
            else
            begin
                want = pending_tokens.pop_front();
                check_field("kind", 32'(want.kind), 32'(tok_if.kind));
                check_field("data", 32'(want.data), 32'(tok_if.data));
                check_field("operator_code", 32'(want.op), 32'(tok_if.operator_code));
                check_field("token_index", 32'(want.idx), 32'(tok_if.token_index));
                check_field("limit_hit", 32'(want.lim), 32'(tok_if.limit_hit));
                check_field("last", 32'(want.last), 32'(tok_if.last));
            end
        end
    end

    // watchdog on cycles with no word moving on either channel
    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((cmd_if.valid === 1'b1 && cmd_if.ready === 1'b1) ||
                 (tok_if.valid === 1'b1 && tok_if.ready === 1'b1))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_CYCLES)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule
